/* rtl/sae_pkg.sv */
// ----------------------------------------------------------------------------
// sae_pkg
// shared types and constants of the stack arithmetic engine
// ----------------------------------------------------------------------------
`default_nettype none

package sae_pkg;

  localparam int SAE_STACK_DEPTH = 16;
  localparam int SAE_DATA_W      = 32;
  localparam int SAE_CMD_W       = 3;
  localparam int SAE_STATUS_W    = 2;
  localparam int SAE_ENTRIES_W   = 5;

  typedef enum logic [SAE_CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_MUL     = 3'd2,
    CMD_DIV     = 3'd3,
    CMD_SUM_ALL = 3'd4,
    CMD_MUL_ALL = 3'd5
  } cmd_t;

  typedef enum logic [SAE_STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t               op;
    logic [SAE_DATA_W-1:0] x;
    logic [SAE_DATA_W-1:0] y;
  } alu_req_t;

endpackage

`default_nettype wire

/* rtl/sae_ram.sv */
// ----------------------------------------------------------------------------
// sae_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/sae_alu.sv */
// ----------------------------------------------------------------------------
// sae_alu
// shared add, subtract and low-word multiply unit
// ----------------------------------------------------------------------------
`default_nettype none

module sae_alu
  import sae_pkg::*;
(
  input  wire alu_req_t              req,
  output logic [SAE_DATA_W:0]        res
);

  logic [SAE_DATA_W-1:0] prod;

  assign prod = req.x * req.y;

  always_comb begin
    unique case (req.op)
      ALU_ADD: res = {1'b0, req.x} + {1'b0, req.y};
      ALU_SUB: res = {1'b0, req.x} - {1'b0, req.y};
      ALU_MUL: res = {1'b0, prod};
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/stack_arithmetic_engine.sv */
// ----------------------------------------------------------------------------
// stack_arithmetic_engine
// bounded integer stack calculator driven by a command stream
// ----------------------------------------------------------------------------
// each input transaction carries a command in s_tuser and a push value in
// s_tdata; each command gives exactly one output transaction with the
// result (zero for push, invalid commands and errors) and entry count in
// m_tdata and the status in m_tuser.
// the stack lives in a one-write one-read memory with registered reads, and
// the results are computed in one shared add/subtract/multiply unit; only
// the divide operands are made positive outside it. a divide takes 32
// restoring steps on the subtractor plus operand reads, setup and sign
// fixup; sum all and multiply all make one memory read and one unit pass per
// entry. the block takes one command at a time: s_tready is high only
// while it waits for a command.
// a finished result sits in the output register until taken; the next
// command may be accepted meanwhile but its result waits for the register.
// reset empties the stack and clears the output valid; memory contents are
// not cleared since only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_arithmetic_engine
  import sae_pkg::*;
#(
  parameter int STACK_DEPTH = SAE_STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // operand[31:0]
  input  wire logic [2:0]  s_tuser,   // command[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // top_value[31:0], entries_held[36:32], zero pad
  output logic [1:0]       m_tuser    // status[1:0]
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_RDA,
    S_RDB,
    S_MUL,
    S_DIV,
    S_DIV_FIX,
    S_OP_WR,
    S_RED_ACC,
    S_RED_WR,
    S_OUT
  } state_t;

  state_t                state;
  cmd_t                  cmd;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [4:0]            step;
  logic                  neg;
  logic [SAE_DATA_W-1:0] a;
  logic [SAE_DATA_W-1:0] b;
  logic [SAE_DATA_W-1:0] q;
  logic [SAE_DATA_W-1:0] rem;
  logic [SAE_DATA_W-1:0] acc;
  logic [SAE_DATA_W-1:0] res_top;
  status_t               res_status;
  logic [SAE_DATA_W-1:0] out_top;
  status_t               out_status;
  logic [SAE_ENTRIES_W-1:0] out_entries;

  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         cnt_m2;
  logic [CW-1:0]         idx_p1;
  logic [31:0]           cnt_ext;
  logic [SAE_DATA_W-1:0] rshift;
  logic                  accept;
  logic                  full;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SAE_DATA_W-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [SAE_DATA_W-1:0] ram_rdata;

  alu_req_t              alu_req;
  logic [SAE_DATA_W:0]   alu_res;

  assign cnt_m1  = count - CW'(1);
  assign cnt_m2  = count - CW'(2);
  assign idx_p1  = idx + CW'(1);
  assign cnt_ext = 32'(count);
  assign rshift  = {rem[SAE_DATA_W-2:0], q[SAE_DATA_W-1]};
  assign full    = (count >= CW'(STACK_DEPTH));

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign m_tdata = {3'b000, out_entries, out_top};
  assign m_tuser = out_status;

  sae_ram #(
    .WIDTH(SAE_DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sae_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = s_tdata;
    ram_raddr = cnt_m1[AW-1:0];
    unique case (state)
      S_IDLE: begin
        ram_we = accept && (cmd_t'(s_tuser) == CMD_PUSH) && !full;
        if (cmd_t'(s_tuser) == CMD_SUM_ALL || cmd_t'(s_tuser) == CMD_MUL_ALL) begin
          ram_raddr = '0;
        end
      end
      S_RDA: ram_raddr = cnt_m2[AW-1:0];
      S_OP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[AW-1:0];
        ram_wdata = res_top;
      end
      S_RED_ACC: ram_raddr = idx_p1[AW-1:0];
      S_RED_WR: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = acc;
      end
      default: ;
    endcase
  end

  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.x  = '0;
    alu_req.y  = '0;
    unique case (state)
      S_RED_ACC: begin
        alu_req.op = (cmd == CMD_SUM_ALL) ? ALU_ADD : ALU_MUL;
        alu_req.x  = acc;
        alu_req.y  = ram_rdata;
      end
      S_MUL: begin
        alu_req.op = ALU_MUL;
        alu_req.x  = a;
        alu_req.y  = b;
      end
      S_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.x  = rshift;
        alu_req.y  = b;
      end
      S_DIV_FIX: begin
        alu_req.op = ALU_SUB;
        alu_req.x  = '0;
        alu_req.y  = q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd     <= cmd_t'(s_tuser);
            res_top <= '0;
            case (cmd_t'(s_tuser))
              CMD_PUSH: begin
                state <= S_OUT;
                if (full) begin
                  res_status <= ST_OVER;
                end else begin
                  res_status <= ST_OK;
                  count      <= count + CW'(1);
                end
              end
              CMD_POP: begin
                if (count == '0) begin
                  res_status <= ST_UNDER;
                  state      <= S_OUT;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_POP;
                end
              end
              CMD_MUL, CMD_DIV: begin
                if (count < CW'(2)) begin
                  res_status <= ST_UNDER;
                  state      <= S_OUT;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_RDA;
                end
              end
              CMD_SUM_ALL, CMD_MUL_ALL: begin
                res_status <= ST_OK;
                acc   <= (cmd_t'(s_tuser) == CMD_SUM_ALL) ? '0 : SAE_DATA_W'(1);
                idx   <= '0;
                state <= (count == '0) ? S_RED_WR : S_RED_ACC;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_POP: begin
          res_top <= ram_rdata;
          count   <= cnt_m1;
          state   <= S_OUT;
        end
        S_RDA: begin
          a     <= ram_rdata;
          state <= S_RDB;
        end
        S_RDB: begin
          if (cmd == CMD_MUL) begin
            b     <= ram_rdata;
            state <= S_MUL;
          end else if (ram_rdata == '0) begin
            res_status <= ST_DIVZERO;
            state      <= S_OUT;
          end else begin
            neg   <= a[SAE_DATA_W-1] ^ ram_rdata[SAE_DATA_W-1];
            q     <= a[SAE_DATA_W-1] ? (~a + SAE_DATA_W'(1)) : a;
            b     <= ram_rdata[SAE_DATA_W-1] ? (~ram_rdata + SAE_DATA_W'(1)) : ram_rdata;
            rem   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_MUL: begin
          res_top <= alu_res[SAE_DATA_W-1:0];
          state   <= S_OP_WR;
        end
        S_DIV: begin
          if (!alu_res[SAE_DATA_W]) begin
            rem <= alu_res[SAE_DATA_W-1:0];
            q   <= {q[SAE_DATA_W-2:0], 1'b1};
          end else begin
            rem <= rshift;
            q   <= {q[SAE_DATA_W-2:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= S_DIV_FIX;
          end
        end
        S_DIV_FIX: begin
          res_top <= neg ? alu_res[SAE_DATA_W-1:0] : q;
          state   <= S_OP_WR;
        end
        S_OP_WR: begin
          count <= cnt_m1;
          state <= S_OUT;
        end
        S_RED_ACC: begin
          acc <= alu_res[SAE_DATA_W-1:0];
          idx <= idx_p1;
          if (idx_p1 == count) begin
            state <= S_RED_WR;
          end
        end
        S_RED_WR: begin
          count   <= CW'(1);
          res_top <= acc;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_top     <= res_top;
            out_status  <= res_status;
            out_entries <= cnt_ext[SAE_ENTRIES_W-1:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
